// File: hw/rtl/rbb_pkg.sv
// Shared types and constants of the RGB box blur window unit.
// Used by rbb_div_cell, rgb_box_blur_window_unit and the testbench; depends on nothing.
package rbb_pkg;

  localparam int MAX_HALF_DEF  = 7;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CH_W = 8;

  localparam logic [2:0]  HALF_WIDTH_RST   = 3'd1;
  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;

  typedef enum logic [1:0] {
    REG_HALF_WIDTH   = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FLUSH,
    S_LAUNCH,
    S_DIV,
    S_PUSH
  } state_e;

endpackage

// File: hw/rtl/rbb_div_cell.sv
// One cell of the divider chain: decides one quotient bit for all three channels.
// Depends on rbb_pkg for the channel width.
module rbb_div_cell #(
  parameter int SUM_W = 16,
  parameter int CNT_W = 8,
  parameter int BIT   = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic [2:0][SUM_W-1:0]                 rem_i,
  input  logic [2:0][rbb_pkg::CH_W-1:0]         quo_i,
  input  logic [CNT_W-1:0]                      div_i,
  output logic                                  valid_o,
  output logic [2:0][SUM_W-1:0]                 rem_o,
  output logic [2:0][rbb_pkg::CH_W-1:0]         quo_o,
  output logic [CNT_W-1:0]                      div_o
);

  logic                          valid_q;
  logic [2:0][SUM_W-1:0]         rem_d, rem_q;
  logic [2:0][rbb_pkg::CH_W-1:0] quo_d, quo_q;
  logic [CNT_W-1:0]              div_q;
  logic [SUM_W-1:0]              dsh;

  // The divisor shifted to this cell's bit position.
  assign dsh = SUM_W'(div_i) << BIT;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (rem_i[k] >= dsh) begin
        rem_d[k] = rem_i[k] - dsh;
        quo_d[k] = quo_i[k] | (rbb_pkg::CH_W'(1) << BIT);
      end else begin
        rem_d[k] = rem_i[k];
        quo_d[k] = quo_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign div_o   = div_q;

endmodule

// File: hw/rtl/rgb_box_blur_window_unit.sv
// Top level of the RGB box blur window unit: line ring, window scan and output.
// Depends on rbb_pkg and rbb_div_cell.
//
// The unit takes a raster-order RGB frame one pixel item at a time, keeps the
// last 2*MAX_HALF+1 lines in a ring memory, and emits each blurred pixel with
// its row and column as soon as its whole window has arrived. Interior pixels
// get the truncated mean of the window without its center; border pixels get
// the truncated mean of the window clipped to the frame, center included.
// Every item, pixel or drain, is followed by up to MAX_HALF+1 results; drain
// items flush the last rows once the frame is complete, and run_last_o marks
// the final result of an item. The window is read from the line memory one
// pixel per cycle over its single read port, followed by the eight-cell
// divider chain and the output register. The unit takes no new item until the
// results of the current one are in the output register; a result waiting
// there does not block it. A write to any configuration register restarts
// the frame; the line memory keeps its contents and needs no clearing after
// reset.
module rgb_box_blur_window_unit #(
  parameter int MAX_HALF  = rbb_pkg::MAX_HALF_DEF,
  parameter int MAX_WIDTH = rbb_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [7:0]                    in_c0_i,
  input  logic [7:0]                    in_c1_i,
  input  logic [7:0]                    in_c2_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_c0_o,
  output logic [7:0]                    out_c1_o,
  output logic [7:0]                    out_c2_o,
  output logic [15:0]                   out_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  out_col_o,
  output logic                          frame_end_o,
  output logic                          run_last_o
);

  localparam int RING     = 2 * MAX_HALF + 1;
  localparam int RW       = $clog2(RING);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int HW       = $clog2(MAX_HALF + 1);
  localparam int EMIT_CAP = MAX_HALF + 1;
  localparam int NW       = $clog2(MAX_HALF + 2);
  localparam int SUM_W    = $clog2(RING * RING * 255 + 1);
  localparam int CNT_W    = $clog2(RING * RING + 1);
  localparam int DEPTH    = RING * (2 ** CW);
  localparam int NCELL    = rbb_pkg::CH_W;

  // Configuration registers.
  logic [2:0]  half_q;
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic        restart;

  // Effective settings after clamping out-of-range values.
  logic [HW-1:0] eff_m;
  logic [WW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic [CW-1:0] w_m1;
  logic [15:0]   h_m1;

  // Frame position of input and output.
  logic [15:0]   in_row_q, out_row_q;
  logic [CW-1:0] in_col_q, out_col_q;
  logic [RW-1:0] in_ring_q, out_ring_q;
  logic          frame_done_q;
  logic [NW-1:0] n_q;

  rbb_pkg::state_e state_q, state_d;

  // Current job: the pixel being blurred and its window.
  logic [15:0]   jr_q, r1_q, sr_q;
  logic [CW-1:0] jc_q, c0_q, c1_q, sc_q;
  logic [RW-1:0] sring_q;
  logic          interior_q, fe_q;

  // Window arithmetic on the output position.
  logic [16:0]   or_pm;
  logic [CW:0]   oc_pm;
  logic [15:0]   nr, r0;
  logic [CW-1:0] nc, c0;
  logic          interior, cond, more, last_px;
  logic [RW-1:0] dr, start_ring;

  // Control strobes.
  logic in_ready, store_px, job_go, scan_en, rd_en, last_issue, div_start, push_load;

  // Memory and accumulation.
  logic [3*rbb_pkg::CH_W-1:0] mem_q [DEPTH];
  logic [3*rbb_pkg::CH_W-1:0] rd_data_q;
  logic [RW+CW-1:0]           raddr, waddr;
  logic                       rd_vld_q;
  logic [2:0][SUM_W-1:0]      sum_q;
  logic [CNT_W-1:0]           cnt_q;

  // Divider chain.
  logic [NCELL:0]                     cv;
  logic [2:0][SUM_W-1:0]              crem [NCELL+1];
  logic [2:0][rbb_pkg::CH_W-1:0]      cquo [NCELL+1];
  logic [CNT_W-1:0]                   cdiv [NCELL+1];
  logic [2:0][rbb_pkg::CH_W-1:0]      res_q;

  // Output register.
  logic                     out_valid_q, run_last_q, frame_end_q;
  logic [2:0][7:0]          out_ch_q;
  logic [15:0]              out_row_r_q;
  logic [CW-1:0]            out_col_r_q;

  // ------------------------------------------------------------------
  // Configuration.
  // ------------------------------------------------------------------
  assign restart = cfg_we_i && (cfg_idx_i == rbb_pkg::REG_HALF_WIDTH ||
                                cfg_idx_i == rbb_pkg::REG_IMAGE_WIDTH ||
                                cfg_idx_i == rbb_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= rbb_pkg::HALF_WIDTH_RST;
      width_q  <= rbb_pkg::IMAGE_WIDTH_RST;
      height_q <= rbb_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbb_pkg::REG_HALF_WIDTH:   half_q   <= cfg_data_i[2:0];
        rbb_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[10:0];
        rbb_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (half_q == 3'd0) begin
      eff_m = HW'(1);
    end else if (32'(half_q) > MAX_HALF) begin
      eff_m = HW'(MAX_HALF);
    end else begin
      eff_m = HW'(half_q);
    end
    if (width_q == 11'd0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
  end

  assign w_m1 = CW'(eff_w - WW'(1));
  assign h_m1 = eff_h - 16'd1;

  // ------------------------------------------------------------------
  // Window of the next output pixel and whether it has fully arrived.
  // The bottom-right corner of the window must lie before the input
  // position in raster order, which is a row/column comparison.
  // ------------------------------------------------------------------
  always_comb begin
    or_pm = {1'b0, out_row_q} + 17'(eff_m);
    oc_pm = {1'b0, out_col_q} + (CW+1)'(eff_m);
    nr    = (or_pm > {1'b0, h_m1}) ? h_m1 : or_pm[15:0];
    nc    = (oc_pm > {1'b0, w_m1}) ? w_m1 : oc_pm[CW-1:0];
    r0    = (out_row_q >= 16'(eff_m)) ? out_row_q - 16'(eff_m) : 16'd0;
    c0    = (out_col_q >= CW'(eff_m)) ? out_col_q - CW'(eff_m) : '0;
    interior = (out_row_q >= 16'(eff_m)) && (out_col_q >= CW'(eff_m)) &&
               (or_pm <= {1'b0, h_m1}) && (oc_pm <= {1'b0, w_m1});
    cond  = frame_done_q || (nr < in_row_q) || ((nr == in_row_q) && (nc < in_col_q));
    more  = (32'(n_q) + 1 < EMIT_CAP) && cond;
    dr    = RW'(out_row_q - r0);
    start_ring = (out_ring_q >= dr) ? out_ring_q - dr : out_ring_q + RW'(RING) - dr;
    last_px = ({1'b0, out_row_q} + 17'd1 >= {1'b0, eff_h}) &&
              ((CW+1)'(out_col_q) + (CW+1)'(1) >= (CW+1)'(eff_w));
  end

  assign last_issue = (sr_q == r1_q) && (sc_q == c1_q);

  // ------------------------------------------------------------------
  // Sequencer.
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbb_pkg::S_IDLE:   if (in_valid_i) state_d = rbb_pkg::S_CHECK;
      rbb_pkg::S_CHECK: begin
        if ((32'(n_q) < EMIT_CAP) && cond) begin
          state_d = rbb_pkg::S_SCAN;
        end else begin
          state_d = rbb_pkg::S_IDLE;
        end
      end
      rbb_pkg::S_SCAN:   if (last_issue) state_d = rbb_pkg::S_FLUSH;
      rbb_pkg::S_FLUSH:  state_d = rbb_pkg::S_LAUNCH;
      rbb_pkg::S_LAUNCH: state_d = rbb_pkg::S_DIV;
      rbb_pkg::S_DIV:    if (cv[NCELL]) state_d = rbb_pkg::S_PUSH;
      rbb_pkg::S_PUSH:   if (!out_valid_q || out_ready_i) state_d = rbb_pkg::S_CHECK;
      default:           state_d = rbb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_q == rbb_pkg::S_IDLE);
    store_px  = in_ready && in_valid_i && (kind_i == rbb_pkg::KIND_PIXEL) && !frame_done_q;
    job_go    = (state_q == rbb_pkg::S_CHECK) && (32'(n_q) < EMIT_CAP) && cond;
    scan_en   = (state_q == rbb_pkg::S_SCAN);
    rd_en     = scan_en && !(interior_q && (sr_q == jr_q) && (sc_q == jc_q));
    div_start = (state_q == rbb_pkg::S_LAUNCH);
    push_load = (state_q == rbb_pkg::S_PUSH) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------------------
  // Frame counters. Configuration writes must come only while idle; not enforced.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q     <= '0;
      in_col_q     <= '0;
      in_ring_q    <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_ring_q   <= '0;
      frame_done_q <= 1'b0;
      n_q          <= '0;
    end else if (restart) begin
      in_row_q     <= '0;
      in_col_q     <= '0;
      in_ring_q    <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_ring_q   <= '0;
      frame_done_q <= 1'b0;
    end else begin
      if (in_ready && in_valid_i) begin
        n_q <= '0;
      end else if (push_load) begin
        n_q <= n_q + NW'(1);
      end
      if (store_px) begin
        if (in_col_q == w_m1) begin
          in_col_q <= '0;
          if (in_row_q == h_m1) begin
            in_row_q     <= '0;
            in_ring_q    <= '0;
            frame_done_q <= 1'b1;
          end else begin
            in_row_q  <= in_row_q + 16'd1;
            in_ring_q <= (in_ring_q == RW'(RING - 1)) ? '0 : in_ring_q + RW'(1);
          end
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (job_go) begin
        if (out_col_q == w_m1) begin
          out_col_q <= '0;
          if (out_row_q == h_m1) begin
            out_row_q    <= '0;
            out_ring_q   <= '0;
            frame_done_q <= 1'b0;
          end else begin
            out_row_q  <= out_row_q + 16'd1;
            out_ring_q <= (out_ring_q == RW'(RING - 1)) ? '0 : out_ring_q + RW'(1);
          end
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Job registers and window scan.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (job_go) begin
      jr_q       <= out_row_q;
      jc_q       <= out_col_q;
      r1_q       <= nr;
      c0_q       <= c0;
      c1_q       <= nc;
      sr_q       <= r0;
      sc_q       <= c0;
      sring_q    <= start_ring;
      interior_q <= interior;
      fe_q       <= last_px;
    end else if (scan_en) begin
      if (sc_q == c1_q) begin
        sc_q    <= c0_q;
        sr_q    <= sr_q + 16'd1;
        sring_q <= (sring_q == RW'(RING - 1)) ? '0 : sring_q + RW'(1);
      end else begin
        sc_q <= sc_q + CW'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // Line ring memory: one write port for incoming pixels, one read port
  // for the window scan.
  // ------------------------------------------------------------------
  assign waddr = {in_ring_q, in_col_q};
  assign raddr = {sring_q, sc_q};

  always_ff @(posedge clk_i) begin
    if (store_px) begin
      mem_q[waddr] <= {in_c2_i, in_c1_i, in_c0_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_go) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (rd_vld_q) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= sum_q[k] + SUM_W'(rd_data_q[k*rbb_pkg::CH_W +: rbb_pkg::CH_W]);
      end
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // ------------------------------------------------------------------
  // Divider chain: each cell settles one quotient bit, most significant
  // first. The mean never exceeds 255, so eight cells suffice.
  // ------------------------------------------------------------------
  assign cv[0]   = div_start;
  assign crem[0] = sum_q;
  assign cquo[0] = '0;
  assign cdiv[0] = cnt_q;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rbb_div_cell #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W),
      .BIT   (NCELL - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .rem_i   (crem[g]),
      .quo_i   (cquo[g]),
      .div_i   (cdiv[g]),
      .valid_o (cv[g+1]),
      .rem_o   (crem[g+1]),
      .quo_o   (cquo[g+1]),
      .div_o   (cdiv[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cv[NCELL]) begin
      res_q <= cquo[NCELL];
    end
  end

  // ------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_load) begin
      out_ch_q    <= res_q;
      out_row_r_q <= jr_q;
      out_col_r_q <= jc_q;
      frame_end_q <= fe_q;
      run_last_q  <= !more;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_c0_o    = out_ch_q[0];
  assign out_c1_o    = out_ch_q[1];
  assign out_c2_o    = out_ch_q[2];
  assign out_row_o   = out_row_r_q;
  assign out_col_o   = out_col_r_q;
  assign frame_end_o = frame_end_q;
  assign run_last_o  = run_last_q;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == rbb_pkg::S_CHECK))
    else $error("accepted item did not start the result check");

  a_div_out_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[NCELL] |-> (state_q == rbb_pkg::S_DIV))
    else $error("divider result outside the divide wait");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbb_pkg::S_LAUNCH) |-> (cnt_q != '0))
    else $error("empty window at divider launch");

  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_load |-> (32'(n_q) < EMIT_CAP))
    else $error("too many results for one item");

endmodule

// File: tb/tb_rgb_box_blur_window_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of rgb_box_blur_window_unit: directed table plus random frames.
// Depends on rbb_pkg and the RTL of the unit; reads no files.
module tb_rgb_box_blur_window_unit;

  localparam int RING      = 2 * rbb_pkg::MAX_HALF_DEF + 1;
  localparam int SETTLE    = 2500;   // eight results of the widest window, with margin
  localparam int IDLE_LIMIT = 40000;

  // Clock and the ports of the unit.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [7:0]  in_c0_i = '0, in_c1_i = '0, in_c2_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_c0_o, out_c1_o, out_c2_o;
  logic [15:0] out_row_o;
  logic [9:0]  out_col_o;
  logic        frame_end_o, run_last_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_box_blur_window_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .kind_i(kind_i),
    .in_c0_i(in_c0_i), .in_c1_i(in_c1_i), .in_c2_i(in_c2_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_c0_o(out_c0_o), .out_c1_o(out_c1_o), .out_c2_o(out_c2_o),
    .out_row_o(out_row_o), .out_col_o(out_col_o),
    .frame_end_o(frame_end_o), .run_last_o(run_last_o)
  );

  // One blurred pixel as the unit should emit it.
  typedef struct packed {
    logic [7:0]  c0, c1, c2;
    logic [15:0] row;
    logic [9:0]  col;
    logic        fend;
    logic        last;
  } blur_px_t;

  blur_px_t expected_pixels[$];

  // Shadow copy of the unit: line ring, raw registers and frame counters.
  logic [23:0] ring_mem [RING * rbb_pkg::MAX_WIDTH_DEF];
  logic [2:0]  half_reg;
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  int unsigned rx_row, rx_col, tx_row, tx_col;
  bit          frame_complete;

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frames_run = 0;

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > rbb_pkg::MAX_WIDTH_DEF) return rbb_pkg::MAX_WIDTH_DEF;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  function automatic int unsigned eff_m();
    if (half_reg == 0) return 1;
    if (half_reg > rbb_pkg::MAX_HALF_DEF) return rbb_pkg::MAX_HALF_DEF;
    return 32'(half_reg);
  endfunction

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic int unsigned ring_slot(int unsigned r, int unsigned c);
    return (r % RING) * rbb_pkg::MAX_WIDTH_DEF + (c % rbb_pkg::MAX_WIDTH_DEF);
  endfunction

  // Mean of the window around (r, c): the center is left out only for interior pixels,
  // and border windows are clipped to the frame with both ends inclusive.
  task automatic window_mean(input int unsigned r, input int unsigned c,
                             output logic [7:0] m0, output logic [7:0] m1,
                             output logic [7:0] m2);
    int unsigned w, h, m, r0, r1, q0, q1, cnt, s0, s1, s2;
    bit          inner;
    logic [23:0] v;
    w = eff_w(); h = eff_h(); m = eff_m();
    inner = (r >= m) && (c >= m) && (r + m < h) && (c + m < w);
    r0 = (r >= m) ? r - m : 0;
    r1 = min_u(r + m, h - 1);
    q0 = (c >= m) ? c - m : 0;
    q1 = min_u(c + m, w - 1);
    cnt = 0; s0 = 0; s1 = 0; s2 = 0;
    for (int unsigned i = r0; i <= r1; i++) begin
      for (int unsigned j = q0; j <= q1; j++) begin
        if (!(inner && i == r && j == c)) begin
          v = ring_mem[ring_slot(i, j)];
          s0 += 32'(v[7:0]); s1 += 32'(v[15:8]); s2 += 32'(v[23:16]);
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    m0 = 8'(s0 / cnt); m1 = 8'(s1 / cnt); m2 = 8'(s2 / cnt);
  endtask

  // Any register write restarts the frame; the line ring keeps its contents.
  task automatic restart_frame();
    rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
    frame_complete = 1'b0;
  endtask

  // Applies one accepted item to the shadow state and queues the blurred pixels it
  // releases. With has_fixed set, the channels come from the stimulus table instead.
  task automatic blur_predict_step(input rbb_pkg::kind_e k, input logic [7:0] p0,
                                   input logic [7:0] p1,
                                   input logic [7:0] p2, input bit has_fixed,
                                   input logic [7:0] f0, input logic [7:0] f1,
                                   input logic [7:0] f2);
    int unsigned w, h, m, n, got, need;
    blur_px_t    px;
    w = eff_w(); h = eff_h(); m = eff_m(); n = 0;
    // A pixel item is stored only while the frame is still coming in.
    if (k == rbb_pkg::KIND_PIXEL && !frame_complete) begin
      ring_mem[ring_slot(rx_row, rx_col)] = {p2, p1, p0};
      rx_col++;
      if (rx_col >= w) begin
        rx_col = 0;
        rx_row++;
        if (rx_row >= h) begin
          rx_row = 0;
          frame_complete = 1'b1;
        end
      end
    end
    while (n < rbb_pkg::MAX_HALF_DEF + 1) begin
      got  = frame_complete ? h * w : rx_row * w + rx_col;
      need = min_u(tx_row + m, h - 1) * w + min_u(tx_col + m, w - 1);
      if (!(frame_complete || need < got)) break;
      window_mean(tx_row, tx_col, px.c0, px.c1, px.c2);
      if (has_fixed) begin
        px.c0 = f0; px.c1 = f1; px.c2 = f2;
      end
      px.row  = tx_row[15:0];
      px.col  = tx_col[9:0];
      px.fend = (tx_row + 1 >= h) && (tx_col + 1 >= w);
      px.last = 1'b0;
      tx_col++;
      if (tx_col >= w) begin
        tx_col = 0;
        tx_row++;
        if (tx_row >= h) begin
          tx_row = 0;
          frame_complete = 1'b0;
        end
      end
      expected_pixels.push_back(px);
      n++;
    end
    if (n > 0) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
  endtask

  // Result checker and idle watchdog. Outputs are sampled at the rising edge,
  // before the unit's registers update.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    blur_px_t want, seen;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        seen = '{out_c0_o, out_c1_o, out_c2_o, out_row_o, out_col_o, frame_end_o, run_last_o};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", seen);
        end else begin
          want = expected_pixels.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at row %0d col %0d: expected %p, got %p",
                       want.row, want.col, want, seen);
          end
        end
      end
    end
  end

  // The receiver stalls with a randomly chosen duty that changes over the run,
  // including stretches where it never stalls.
  int unsigned ready_pct = 100;
  int unsigned pattern_cnt = 0;
  always @(negedge clk_i) begin
    pattern_cnt++;
    if (pattern_cnt % 300 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 15;
      endcase
    end
    out_ready_i = ($urandom_range(0, 99) < ready_pct);
  end

  // Register write; the shadow copy follows at the same edge.
  task automatic write_reg(input rbb_pkg::reg_idx_e idx, input logic [15:0] data);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      rbb_pkg::REG_HALF_WIDTH:   half_reg   = data[2:0];
      rbb_pkg::REG_IMAGE_WIDTH:  width_reg  = data[10:0];
      default:                   height_reg = data[15:0];
    endcase
    restart_frame();
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Waits, at a falling edge, until every expected result has come and the unit has
  // had time to finish an item that released nothing.
  task automatic wait_quiet();
    in_valid_i = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Offers one item from a falling edge and returns at the falling edge after its
  // acceptance, with valid still high.
  task automatic send_item(input rbb_pkg::kind_e k, input logic [7:0] p0,
                           input logic [7:0] p1,
                           input logic [7:0] p2, input bit has_fixed,
                           input logic [7:0] f0, input logic [7:0] f1, input logic [7:0] f2);
    kind_i = k; in_c0_i = p0; in_c1_i = p1; in_c2_i = p2;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    blur_predict_step(k, p0, p1, p2, has_fixed, f0, f1, f2);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Sender bursts: after a burst of random length, valid usually drops for a random gap.
  int unsigned burst_left = 0;
  task automatic sender_pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_random(input rbb_pkg::kind_e k);
    sender_pace();
    send_item(k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'b0, 8'd0, 8'd0, 8'd0);
  endtask

  // Directed stimulus: a register write or an item, with channels typed in where the
  // answer is obvious (uniform frames and one-pixel frames).
  typedef struct {
    bit                 is_cfg;
    rbb_pkg::reg_idx_e  idx;
    logic [15:0]        data;
    rbb_pkg::kind_e     kind;
    logic [7:0]         c0, c1, c2;
    bit                 has_fixed;
    logic [7:0]         e0, e1, e2;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic void add_cfg(rbb_pkg::reg_idx_e idx, logic [15:0] data);
    dir_tab.push_back('{1'b1, idx, data, rbb_pkg::KIND_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0,
                        8'd0, 8'd0, 8'd0});
  endfunction

  function automatic void add_item(rbb_pkg::kind_e k, logic [7:0] a, logic [7:0] b,
                                   logic [7:0] c,
                                   bit fx, logic [7:0] ea, logic [7:0] eb, logic [7:0] ec);
    dir_tab.push_back('{1'b0, rbb_pkg::REG_HALF_WIDTH, 16'd0, k, a, b, c, fx, ea, eb, ec});
  endfunction

  initial begin
    int unsigned w, h, npx, cut;
    half_reg = rbb_pkg::HALF_WIDTH_RST;
    width_reg = rbb_pkg::IMAGE_WIDTH_RST;
    height_reg = rbb_pkg::IMAGE_HEIGHT_RST;
    restart_frame();

    // An 8x2 white frame with radius 1: the last pixel item leaves two results
    // pending, so the pixel item after it is not stored and only flushes them.
    // A drain item then finds nothing ready.
    add_cfg(rbb_pkg::REG_HALF_WIDTH, 16'd1);
    add_cfg(rbb_pkg::REG_IMAGE_WIDTH, 16'd8);
    add_cfg(rbb_pkg::REG_IMAGE_HEIGHT, 16'd2);
    for (int i = 0; i < 16; i++)
      add_item(rbb_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    add_item(rbb_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    add_item(rbb_pkg::KIND_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
    // Zero in every register acts as one: a one-pixel frame echoes its pixel.
    add_cfg(rbb_pkg::REG_HALF_WIDTH, 16'd0);
    add_cfg(rbb_pkg::REG_IMAGE_WIDTH, 16'd0);
    add_cfg(rbb_pkg::REG_IMAGE_HEIGHT, 16'd0);
    add_item(rbb_pkg::KIND_PIXEL, 8'd12, 8'd34, 8'd56, 1'b1, 8'd12, 8'd34, 8'd56);
    add_item(rbb_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00);
    add_item(rbb_pkg::KIND_PIXEL, 8'hFF, 8'h00, 8'hA5, 1'b1, 8'hFF, 8'h00, 8'hA5);
    add_item(rbb_pkg::KIND_PIXEL, 8'h5A, 8'hFF, 8'h01, 1'b1, 8'h5A, 8'hFF, 8'h01);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (i == 0 || !dir_tab[i - 1].is_cfg) wait_quiet();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].kind, dir_tab[i].c0, dir_tab[i].c1, dir_tab[i].c2,
                  dir_tab[i].has_fixed, dir_tab[i].e0, dir_tab[i].e1, dir_tab[i].e2);
      end
    end

    // Largest settings: radius 7, width above the limit and the tallest frame. Only 20
    // pixels of the first row go in, so no window completes and nothing unwritten is ever read.
    wait_quiet();
    write_reg(rbb_pkg::REG_HALF_WIDTH, 16'd7);
    write_reg(rbb_pkg::REG_IMAGE_WIDTH, 16'd2047);
    write_reg(rbb_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
    for (int i = 0; i < 20; i++) send_random(rbb_pkg::KIND_PIXEL);

    // Random frames of small size. Most are complete frames with drain items after
    // them; some carry stray drain items, and a few are cut short before the next
    // register write.
    while (items_sent < 460) begin
      wait_quiet();
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      write_reg(rbb_pkg::REG_HALF_WIDTH, 16'($urandom_range(0, 7)));
      write_reg(rbb_pkg::REG_IMAGE_WIDTH, 16'(w));
      write_reg(rbb_pkg::REG_IMAGE_HEIGHT, 16'(h));
      npx = w * h;
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, npx - 1) : npx;
      for (int unsigned p = 0; p < cut; p++) begin
        if ($urandom_range(0, 9) == 0) send_random(rbb_pkg::KIND_DRAIN);
        send_random(rbb_pkg::KIND_PIXEL);
      end
      if (cut == npx) begin
        frames_run++;
        while (frame_complete)
          send_random(($urandom_range(0, 4) == 0) ? rbb_pkg::KIND_PIXEL
                                                  : rbb_pkg::KIND_DRAIN);
        // The next write waits for all results, which also gives the sender a long
        // pause with nothing outstanding.
      end
    end

    wait_quiet();
    if (expected_pixels.size() != 0) mismatches += expected_pixels.size();
    $display("covered %0d items, %0d blurred pixels, %0d complete random frames",
             items_sent, results_seen, frames_run);
    $display("radius 0 to 7, widths 0 to 2047, heights 0 to 65535, stalls on both sides");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: rgb_box_blur_window_unit.f
hw/rtl/rbb_pkg.sv
hw/rtl/rbb_div_cell.sv
hw/rtl/rgb_box_blur_window_unit.sv
tb/tb_rgb_box_blur_window_unit.sv
